// ----- hw/rtl/wba_pkg.sv -----
// Package with the payload types, opcodes and pipeline constants of the word/byte ALU.
`default_nettype none

package wba_pkg;

    // Operand widths: full word and byte mode.
    localparam int DATA_W      = 16;
    localparam int BYTE_W      = 8;
    // Shift counts up to and including DATA_W need this many bits.
    localparam int CNT_W       = $clog2(DATA_W + 1);
    // The divider retires this many quotient bits in each stage.
    localparam int DIV_BITS    = 2;
    localparam int DIV_STAGES  = DATA_W / DIV_BITS;

    localparam logic [DATA_W-1:0] BYTE_MASK = DATA_W'({BYTE_W{1'b1}});

    // Operation codes.
    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_MUL  = 4'd2;
    localparam logic [3:0] OP_DIV  = 4'd3;
    localparam logic [3:0] OP_CMP  = 4'd4;
    localparam logic [3:0] OP_NOT  = 4'd5;
    localparam logic [3:0] OP_AND  = 4'd6;
    localparam logic [3:0] OP_OR   = 4'd7;
    localparam logic [3:0] OP_XOR  = 4'd8;
    localparam logic [3:0] OP_TEST = 4'd9;
    localparam logic [3:0] OP_SHL  = 4'd10;
    localparam logic [3:0] OP_SHR  = 4'd11;

    // Error codes.
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_DIV0   = 2'd1;
    localparam logic [1:0] ERR_OPCODE = 2'd2;

    // One input transfer.
    typedef struct packed {
        logic [3:0]        mode;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
        logic              byte_size;
    } wba_in_t;

    // One result transfer.
    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              zero_flag;
        logic              negative_flag;
        logic              carry_flag;
        logic              overflow_flag;
        logic [1:0]        error_code;
    } wba_out_t;

    // What travels down the pipeline with each item.
    typedef struct packed {
        logic              is_div;
        logic              byte_size;
        logic [1:0]        err;
        logic [DATA_W-1:0] res;
        logic              carry;
        logic              ovf;
        logic [DATA_W-1:0] dvs;
        logic [DATA_W-1:0] rem;
        logic [DATA_W-1:0] quo;
    } wba_stage_t;

    // Sign bit of a value at the operand size.
    function automatic logic sign_bit(input logic [DATA_W-1:0] v, input logic byte_size);
        sign_bit = byte_size ? v[BYTE_W-1] : v[DATA_W-1];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/wba_front.sv -----
// First pipeline stage: operand masking, the multiply and all other operations but the divide.
`default_nettype none

module wba_front import wba_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       en,
    input  wire logic       valid_in,
    input  wire wba_in_t    data_in,
    output logic            valid_out,
    output wba_stage_t      data_out
);

    logic                  valid_reg;
    wba_stage_t            data_reg;
    wba_stage_t            data_next;

    logic [DATA_W-1:0]     mask;
    logic [DATA_W-1:0]     a;
    logic [DATA_W-1:0]     b;
    logic [DATA_W:0]       sum;
    logic [DATA_W-1:0]     add_r;
    logic [DATA_W-1:0]     sub_r;
    logic [2*DATA_W-1:0]   prod;
    logic [CNT_W-1:0]      width_cnt;
    logic [CNT_W-1:0]      cnt;
    logic                  too_far;
    logic [2*DATA_W-1:0]   shl_wide;
    logic [2*DATA_W-1:0]   shr_wide;

    // Operands cut to the operand size.
    assign mask = data_in.byte_size ? BYTE_MASK : {DATA_W{1'b1}};
    assign a    = data_in.operand_a & mask;
    assign b    = data_in.operand_b & mask;

    // Adder, subtractor and multiplier.
    assign sum   = {1'b0, a} + {1'b0, b};
    assign add_r = sum[DATA_W-1:0] & mask;
    assign sub_r = (b - a) & mask;
    assign prod  = a * b;

    // Barrel shifters; a count above the operand width clears everything.
    assign width_cnt = data_in.byte_size ? CNT_W'(BYTE_W) : CNT_W'(DATA_W);
    assign too_far   = (a > DATA_W'(width_cnt));
    assign cnt       = a[CNT_W-1:0];
    assign shl_wide  = {{DATA_W{1'b0}}, b} << cnt;
    assign shr_wide  = {b, {DATA_W{1'b0}}} >> cnt;

    // Operation select.
    always_comb begin
        data_next           = '0;
        data_next.byte_size = data_in.byte_size;
        data_next.err       = ERR_NONE;
        data_next.dvs       = a;
        data_next.rem       = '0;
        data_next.quo       = b;
        case (data_in.mode)
            OP_ADD: begin
                data_next.res   = add_r;
                data_next.carry = data_in.byte_size ? sum[BYTE_W] : sum[DATA_W];
                data_next.ovf   = (sign_bit(a, data_in.byte_size) ==
                                   sign_bit(b, data_in.byte_size)) &&
                                  (sign_bit(add_r, data_in.byte_size) !=
                                   sign_bit(a, data_in.byte_size));
            end
            OP_SUB, OP_CMP: begin
                data_next.res   = sub_r;
                data_next.carry = (a > b);
                data_next.ovf   = (sign_bit(a, data_in.byte_size) !=
                                   sign_bit(b, data_in.byte_size)) &&
                                  (sign_bit(sub_r, data_in.byte_size) !=
                                   sign_bit(b, data_in.byte_size));
            end
            OP_MUL: begin
                data_next.res = prod[DATA_W-1:0] & mask;
            end
            OP_DIV: begin
                data_next.is_div = 1'b1;
                data_next.err    = (a == '0) ? ERR_DIV0 : ERR_NONE;
            end
            OP_NOT: begin
                data_next.res = ~a & mask;
            end
            OP_AND, OP_TEST: begin
                data_next.res = a & b;
            end
            OP_OR: begin
                data_next.res = a | b;
            end
            OP_XOR: begin
                data_next.res = a ^ b;
            end
            OP_SHL: begin
                if (!too_far) begin
                    data_next.res   = shl_wide[DATA_W-1:0] & mask;
                    data_next.carry = data_in.byte_size ? shl_wide[BYTE_W] : shl_wide[DATA_W];
                end
            end
            OP_SHR: begin
                if (!too_far) begin
                    data_next.res   = shr_wide[2*DATA_W-1:DATA_W];
                    data_next.carry = shr_wide[DATA_W-1];
                end
            end
            default: begin
                data_next.err = ERR_OPCODE;
            end
        endcase
    end

    // Stage register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/wba_div_step.sv -----
// One divider stage: retires DIV_BITS quotient bits by restoring division.
`default_nettype none

module wba_div_step import wba_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       en,
    input  wire logic       valid_in,
    input  wire wba_stage_t data_in,
    output logic            valid_out,
    output wba_stage_t      data_out
);

    logic       valid_reg;
    wba_stage_t data_reg;
    wba_stage_t data_next;

    // Shift the next dividend bit into the partial remainder and subtract where it fits.
    always_comb begin
        logic [DATA_W:0] trial;
        logic [DATA_W:0] diff;
        logic            fits;
        data_next = data_in;
        for (int i = 0; i < DIV_BITS; i++) begin
            trial         = {data_next.rem, data_next.quo[DATA_W-1]};
            diff          = trial - {1'b0, data_next.dvs};
            fits          = (trial >= {1'b0, data_next.dvs});
            data_next.rem = fits ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
            data_next.quo = {data_next.quo[DATA_W-2:0], fits};
        end
    end

    // Stage register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/wba_back.sv -----
// Last stage: result select, zero and sign flags, and the output register.
`default_nettype none

module wba_back import wba_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       en,
    input  wire logic       valid_in,
    input  wire wba_stage_t data_in,
    output logic            valid_out,
    output wba_out_t        data_out
);

    logic              valid_reg;
    wba_out_t          data_reg;
    wba_out_t          data_next;
    logic [DATA_W-1:0] res;
    logic              is_err;

    // Errors force a zero result; divide items take the quotient.
    assign is_err = (data_in.err != ERR_NONE);

    always_comb begin
        if (is_err) begin
            res = '0;
        end else if (data_in.is_div) begin
            res = data_in.quo;
        end else begin
            res = data_in.res;
        end
    end

    // Flags.
    always_comb begin
        data_next.result        = res;
        data_next.zero_flag     = (res == '0);
        data_next.negative_flag = sign_bit(res, data_in.byte_size);
        data_next.carry_flag    = data_in.carry & ~is_err;
        data_next.overflow_flag = data_in.ovf & ~is_err;
        data_next.error_code    = data_in.err;
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= data_next;
        end
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/word_byte_alu_with_flags_unit.sv -----
// Top level of the pipelined word/byte ALU with Z, N, C and O flags.
//
//   channel   ports                      direction   payload
//   input     s_valid s_ready s_data     in          wba_in_t (mode, operands, byte_size)
//   result    m_valid m_ready m_data     out         wba_out_t (result, flags, error_code)
//
// One transfer is accepted every cycle while no result waits on a low m_ready. Every
// operation passes ten register stages before its result is offered: one operand stage,
// DIV_STAGES = 8 divider stages of two quotient bits each, and the flag and output
// register stage. The divider chain sets the depth.
// Reset clears only the stage valid bits. A stalled output freezes the whole pipeline,
// so s_ready is low exactly when a result waits and m_ready is low.
`default_nettype none

module word_byte_alu_with_flags_unit import wba_pkg::*; (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire wba_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output wba_out_t      m_data
);

    logic       en;
    logic       stage_valid [0:DIV_STAGES];
    wba_stage_t stage_data  [0:DIV_STAGES];

    // The pipeline moves whenever the output register is empty or being taken.
    assign en      = ~m_valid | m_ready;
    assign s_ready = en;

    wba_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (s_valid),
        .data_in   (s_data),
        .valid_out (stage_valid[0]),
        .data_out  (stage_data[0])
    );

    // Divider chain; other operations ride along with their results unchanged.
    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        wba_div_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .valid_in  (stage_valid[g]),
            .data_in   (stage_data[g]),
            .valid_out (stage_valid[g+1]),
            .data_out  (stage_data[g+1])
        );
    end

    wba_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (stage_valid[DIV_STAGES]),
        .data_in   (stage_data[DIV_STAGES]),
        .valid_out (m_valid),
        .data_out  (m_data)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/wba_checker.sv -----
// Port-level checker for the word/byte ALU and the bind that attaches it.
`default_nettype none

module wba_checker import wba_pkg::*; (
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_valid,
    input wire logic     s_ready,
    input wire wba_in_t  s_data,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire wba_out_t m_data
);

    // A stalled result transfer holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // A waiting result stops the input side.
    a_stall_in: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input accepted while output stalled");

    // Error code is one of the defined codes.
    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.error_code == ERR_NONE) || (m_data.error_code == ERR_DIV0) ||
                    (m_data.error_code == ERR_OPCODE))
        else $error("undefined error code");

    // An error gives a zero result with only Z set.
    a_err_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.error_code != ERR_NONE) |->
            (m_data.result == '0) && m_data.zero_flag && !m_data.negative_flag &&
            !m_data.carry_flag && !m_data.overflow_flag)
        else $error("error result not cleared");

    // Z agrees with the result.
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.zero_flag == (m_data.result == '0)))
        else $error("zero flag mismatch");

    // The input payload is only observed, never asserted on here.
    logic unused_in;
    assign unused_in = s_valid ^ (^s_data);

endmodule

bind word_byte_alu_with_flags_unit wba_checker u_wba_checker (.*);

`default_nettype wire

// ----- verif/word_byte_alu_checker.sv -----
// Checker for the word/byte ALU: predicts each result transfer and compares it field by field.
`timescale 1ns / 100ps

module word_byte_alu_checker import wba_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  wba_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  wba_out_t m_data,
    output int       mismatches,
    output int       awaiting
);

    // Results predicted for accepted operations, oldest first.
    wba_out_t alu_results_q[$];
    int       fault_total = 0;

    // Works out the result and flags of one operation at byte or word size.
    function automatic wba_out_t alu_expect(input wba_in_t op);
        int unsigned w;
        logic [31:0] mask;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] r;
        logic [31:0] wide;
        logic        c;
        logic        o;
        logic [1:0]  err;
        wba_out_t    res;
        w    = op.byte_size ? BYTE_W : DATA_W;
        mask = (32'd1 << w) - 32'd1;
        a    = {16'd0, op.operand_a} & mask;
        b    = {16'd0, op.operand_b} & mask;
        r    = 32'd0;
        c    = 1'b0;
        o    = 1'b0;
        err  = ERR_NONE;
        case (op.mode)
            OP_ADD: begin
                wide = a + b;
                r    = wide & mask;
                c    = wide[w];
                o    = (a[w-1] == b[w-1]) && (r[w-1] != a[w-1]);
            end
            OP_SUB, OP_CMP: begin
                r = (b - a) & mask;
                c = (a > b);
                o = (a[w-1] != b[w-1]) && (r[w-1] != b[w-1]);
            end
            OP_MUL: begin
                r = (a * b) & mask;
            end
            OP_DIV: begin
                if (a == 32'd0) begin
                    err = ERR_DIV0;
                end else begin
                    r = b / a;
                end
            end
            OP_NOT: begin
                r = ~a & mask;
            end
            OP_AND, OP_TEST: begin
                r = a & b;
            end
            OP_OR: begin
                r = a | b;
            end
            OP_XOR: begin
                r = a ^ b;
            end
            OP_SHL: begin
                // A count of exactly w still leaves the last bit shifted out in carry.
                if (a == 32'd0) begin
                    r = b;
                end else if (a <= w) begin
                    c = b[w - a];
                    r = (a < w) ? ((b << a) & mask) : 32'd0;
                end
            end
            OP_SHR: begin
                if (a == 32'd0) begin
                    r = b;
                end else if (a <= w) begin
                    c = b[a - 1];
                    r = (a < w) ? (b >> a) : 32'd0;
                end
            end
            default: begin
                err = ERR_OPCODE;
            end
        endcase
        // Errors give a zero result with every flag but Z clear.
        if (err != ERR_NONE) begin
            r = 32'd0;
            c = 1'b0;
            o = 1'b0;
        end
        res.result        = r[15:0];
        res.zero_flag     = (r == 32'd0);
        res.negative_flag = r[w-1];
        res.carry_flag    = c;
        res.overflow_flag = o;
        res.error_code    = err;
        return res;
    endfunction

    // Reports one field that differs and returns 1 for it.
    function automatic int field_differs(input string name, input int unsigned want,
                                         input int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Both channels are sampled at the rising edge, before the edge's updates land.
    always @(posedge aclk) begin : scoreboard
        wba_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                alu_results_q.push_back(alu_expect(s_data));
            end
            if (m_valid && m_ready) begin
                if (alu_results_q.size() == 0) begin
                    $error("result transfer with no operation outstanding: 0x%0h", m_data);
                    fault_total++;
                end else begin
                    want = alu_results_q.pop_front();
                    fault_total += field_differs("result", want.result, m_data.result);
                    fault_total += field_differs("zero_flag", want.zero_flag,
                                                 m_data.zero_flag);
                    fault_total += field_differs("negative_flag", want.negative_flag,
                                                 m_data.negative_flag);
                    fault_total += field_differs("carry_flag", want.carry_flag,
                                                 m_data.carry_flag);
                    fault_total += field_differs("overflow_flag", want.overflow_flag,
                                                 m_data.overflow_flag);
                    fault_total += field_differs("error_code", want.error_code,
                                                 m_data.error_code);
                end
            end
        end
        mismatches <= fault_total;
        awaiting   <= alu_results_q.size();
    end

endmodule

// ----- verif/word_byte_alu_with_flags_unit_tb.sv -----
// Top of the word/byte ALU testbench: clock, reset, stimulus, back-pressure and the verdict.
`timescale 1ns / 100ps

module word_byte_alu_with_flags_unit_tb;
    import wba_pkg::*;

    localparam int RANDOM_OPS   = 650;
    localparam int HOLD_AT_OP   = 150;
    localparam int HOLD_CYCLES  = 80;
    localparam int QUIET_FIRST  = 300;
    localparam int QUIET_LAST   = 450;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 40000;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    wba_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    wba_out_t m_data;

    int ops_accepted = 0;
    int cycle_count  = 0;
    int mismatches;
    int awaiting;

    always #6 aclk = ~aclk;

    word_byte_alu_with_flags_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    word_byte_alu_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Neither side idles while this stretch of operations is being sent.
    function automatic bit quiet_stretch();
        return (ops_accepted >= QUIET_FIRST) && (ops_accepted < QUIET_LAST);
    endfunction

    function automatic wba_in_t make_op(input logic [3:0] mode, input logic [15:0] a,
                                        input logic [15:0] b, input logic byte_size);
        wba_in_t op;
        op.mode      = mode;
        op.operand_a = a;
        op.operand_b = b;
        op.byte_size = byte_size;
        return op;
    endfunction

    // Operand values: mostly random, with sign and carry boundaries mixed in.
    function automatic logic [15:0] random_operand();
        logic [15:0] v;
        v = 16'($urandom);
        case ($urandom_range(0, 7))
            0: begin
                case ($urandom_range(0, 7))
                    0: v = 16'h0000;
                    1: v = 16'h0001;
                    2: v = 16'h007F;
                    3: v = 16'h0080;
                    4: v = 16'h00FF;
                    5: v = 16'h7FFF;
                    6: v = 16'h8000;
                    default: v = 16'hFFFF;
                endcase
            end
            1: begin
                // Random upper byte over a low byte near its own boundaries.
                v[7:0] = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 2))
                                                     : 8'($urandom_range(8'h7E, 8'h81));
            end
            default: begin
            end
        endcase
        return v;
    endfunction

    function automatic wba_in_t random_op();
        wba_in_t op;
        op.byte_size = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 99) < 8) begin
            op.mode = 4'($urandom_range(OP_SHR + 1, 4'hF));
        end else begin
            op.mode = 4'($urandom_range(OP_ADD, OP_SHR));
        end
        op.operand_a = random_operand();
        op.operand_b = random_operand();
        // Keep most shift counts around the operand width so every edge is reached.
        if ((op.mode == OP_SHL || op.mode == OP_SHR) && $urandom_range(0, 3) != 0) begin
            if (op.byte_size) begin
                op.operand_a[7:0] = 8'($urandom_range(0, 10));
            end else begin
                op.operand_a = 16'($urandom_range(0, 18));
            end
        end
        if (op.mode == OP_DIV && $urandom_range(0, 3) == 0) begin
            op.operand_a[7:0] = 8'($urandom_range(0, 3));
            if (!op.byte_size) begin
                op.operand_a[15:8] = 8'h00;
            end
        end
        return op;
    endfunction

    // Offers one operation and waits for its transfer, then perhaps lets s_valid drop.
    task automatic offer_op(input wba_in_t op);
        s_valid <= 1'b1;
        s_data  <= op;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        ops_accepted++;
        if (!quiet_stretch() && $urandom_range(0, 99) < 8) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // Result side: random stalls, one long hold-off that fills the pipeline.
    initial begin : result_side
        bit held;
        held = 1'b0;
        forever begin
            @(posedge aclk);
            if (!held && ops_accepted >= HOLD_AT_OP) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= quiet_stretch() || ($urandom_range(0, 99) >= 8);
        end
    end

    initial begin : stimulus
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed operations: carries, overflows, size truncation, shift edges, errors.
        offer_op(make_op(OP_ADD,  16'h0001, 16'hFFFF, 1'b0));
        offer_op(make_op(OP_ADD,  16'h0001, 16'h7FFF, 1'b0));
        offer_op(make_op(OP_ADD,  16'hFF80, 16'hA580, 1'b1));
        offer_op(make_op(OP_SUB,  16'h0001, 16'h0000, 1'b0));
        offer_op(make_op(OP_SUB,  16'h0001, 16'h8000, 1'b0));
        offer_op(make_op(OP_CMP,  16'h12FF, 16'h347F, 1'b1));
        offer_op(make_op(OP_CMP,  16'hFFFF, 16'hFFFF, 1'b0));
        offer_op(make_op(OP_MUL,  16'hFFFF, 16'hFFFF, 1'b0));
        offer_op(make_op(OP_MUL,  16'h0110, 16'h0210, 1'b1));
        offer_op(make_op(OP_DIV,  16'h0000, 16'hFFFF, 1'b0));
        offer_op(make_op(OP_DIV,  16'h0100, 16'h00FF, 1'b1));
        offer_op(make_op(OP_DIV,  16'h0001, 16'hFFFF, 1'b0));
        offer_op(make_op(OP_NOT,  16'h0000, 16'h1234, 1'b0));
        offer_op(make_op(OP_NOT,  16'hAB7F, 16'h0000, 1'b1));
        offer_op(make_op(OP_AND,  16'hF0F0, 16'h0F0F, 1'b0));
        offer_op(make_op(OP_OR,   16'h8000, 16'h0001, 1'b0));
        offer_op(make_op(OP_XOR,  16'hFFFF, 16'hFF00, 1'b1));
        offer_op(make_op(OP_TEST, 16'hFFFF, 16'h8080, 1'b0));
        offer_op(make_op(OP_SHL,  16'h0000, 16'hBEEF, 1'b0));
        offer_op(make_op(OP_SHL,  16'h0010, 16'h0001, 1'b0));
        offer_op(make_op(OP_SHL,  16'h0308, 16'h0001, 1'b1));
        offer_op(make_op(OP_SHR,  16'h0011, 16'hFFFF, 1'b0));
        offer_op(make_op(OP_SHR,  16'h0010, 16'h8000, 1'b0));
        offer_op(make_op(OP_SHR,  16'h0001, 16'h0003, 1'b1));
        for (int code = OP_SHR + 1; code <= 4'hF; code++) begin
            offer_op(make_op(4'(code), 16'hFFFF, 16'hFFFF, code[0]));
        end

        repeat (RANDOM_OPS) offer_op(random_op());
        s_valid <= 1'b0;

        // Drain: wait for every predicted result, then keep watching for stray results.
        @(posedge aclk);
        while (awaiting != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0 && awaiting == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
